@@ design/running_median_two_heaps_assert.svh @@
// Assertion helpers used by the running-median RTL file.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH

// Hold cond at every clock edge outside reset.
`define RMTH_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// When pre holds, post must hold at the next edge.
`define RMTH_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ design/rmth_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rmth_pkg;

    localparam int MEDIAN_W = 33;
    localparam int COUNT_W  = 10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PLACE,
        ST_PUSH_UP,
        ST_PUSH_CMP,
        ST_POP_LAST,
        ST_POP_TAIL,
        ST_POP_L,
        ST_POP_R,
        ST_POP_CMP,
        ST_REBAL,
        ST_RESULT
    } t_state;

    // heap select: lower heap is a max-heap, upper heap a min-heap
    typedef enum logic {
        HEAP_LOWER = 1'b0,
        HEAP_UPPER = 1'b1
    } t_heap;

endpackage
`default_nettype wire

@@ design/rmth_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ design/rmth_cmp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Heap order compare: a outranks b (greater for max-heap, smaller for min-heap).
module rmth_cmp #(
    parameter int WIDTH = 32
) (
    input  wire logic signed [WIDTH-1:0] i_a,
    input  wire logic signed [WIDTH-1:0] i_b,
    input  wire logic                    i_is_max,
    output logic                         o_outranks
);
    assign o_outranks = i_is_max ? (i_a > i_b) : (i_a < i_b);
endmodule
`default_nettype wire

@@ design/running_median_two_heaps.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Running median over a stream of signed samples, kept in two heaps.
// Input channel (s_axis): one item per sample; tdata carries the sample, tuser
// the restart flag that empties both heaps before the sample is taken.
// Output channel (m_axis): one item per input item; tdata carries twice the
// median and the count of held samples, tuser flags a sample dropped because
// 2*HEAP_DEPTH-1 samples are already held.
// Sequencing: each item runs through one sequencer that drives a single shared
// compare unit and one read port per heap RAM (registered read). Its steps are
// accept, heap pick, sift-up, balance check and result; a rebalance adds a
// fetch of the tail, a sift-down and a push of the old top into the other
// heap. A dropped sample goes straight from its accept to the result.
// The block takes one item at a time; tready is high only while it waits.
// The result sits in an output register; a stalled receiver holds it there,
// the next item is still accepted and its result waits until the register
// frees. Reset empties both heaps and drops any pending result; heap RAMs
// need no clearing since only entries below the heap sizes are ever used.
module running_median_two_heaps #(
    parameter int HEAP_DEPTH   = 512,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] sample
    input  wire logic        i_s_axis_tuser,   // [0] restart
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [47:0] o_m_axis_tdata,   // [32:0] median_doubled, [42:33] sample_count
    output logic             o_m_axis_tuser    // [0] full_flag
);
    localparam int SW = SAMPLE_WIDTH;
    localparam int IW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int XW = CW + 1;
    localparam logic [XW-1:0] CAPACITY = XW'(2 * HEAP_DEPTH - 1);
    localparam int MW = rmth_pkg::MEDIAN_W;
    localparam int NW = rmth_pkg::COUNT_W;

    rmth_pkg::t_state r_state, n_state;
    rmth_pkg::t_heap  r_hsel, n_hsel;
    logic [CW-1:0] r_lsize, n_lsize, r_usize, n_usize;
    logic [CW-1:0] r_m, n_m;                       // element count during sift-down
    logic [IW-1:0] r_idx, n_idx;                   // hole position
    logic signed [SW-1:0] r_val, n_val;            // value being placed
    logic signed [SW-1:0] r_carry, n_carry;        // top moved by rebalance
    logic signed [SW-1:0] r_cand, n_cand;          // best of hole and left child
    logic r_left_win, n_left_win;
    logic r_full, n_full;
    logic r_rebal, n_rebal;                        // rebalance already done
    logic signed [SW-1:0] r_ltop, r_utop;          // mirrors of heap entry 0
    logic r_out_valid, n_out_valid;
    logic [47:0] r_out_data, n_out_data;
    logic r_out_user, n_out_user;

    // heap RAM ports
    logic we_l, we_u;
    logic [IW-1:0] waddr, raddr;
    logic signed [SW-1:0] wdata;
    logic [SW-1:0] q_l, q_u;
    logic signed [SW-1:0] q;

    // shared compare unit
    logic signed [SW-1:0] cmp_a, cmp_b;
    logic cmp_max, cmp_out;

    logic [XW-1:0] total, child_l, child_r;
    logic [XW-1:0] m_ext;
    logic [CW-1:0] cur_size;
    logic signed [MW-1:0] lt_ext, ut_ext, median;
    logic sizes_fit, sizes_even;

    rmth_ram #(.WIDTH(SW), .DEPTH(HEAP_DEPTH)) u_lower (
        .i_clk(i_clk), .i_we(we_l), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(q_l)
    );

    rmth_ram #(.WIDTH(SW), .DEPTH(HEAP_DEPTH)) u_upper (
        .i_clk(i_clk), .i_we(we_u), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(q_u)
    );

    rmth_cmp #(.WIDTH(SW)) u_cmp (
        .i_a(cmp_a), .i_b(cmp_b), .i_is_max(cmp_max), .o_outranks(cmp_out)
    );

    assign q        = (r_hsel == rmth_pkg::HEAP_UPPER) ? $signed(q_u) : $signed(q_l);
    assign total    = XW'(r_lsize) + XW'(r_usize);
    assign child_l  = XW'({r_idx, 1'b1});
    assign child_r  = child_l + XW'(1);
    assign m_ext    = XW'(r_m);
    assign cur_size = (r_hsel == rmth_pkg::HEAP_UPPER) ? r_usize : r_lsize;
    assign lt_ext   = MW'(r_ltop);
    assign ut_ext   = MW'(r_utop);

    always_comb begin
        median = '0;
        if (r_lsize != '0 && r_lsize == r_usize) begin
            median = lt_ext + ut_ext;
        end else if (r_lsize > r_usize) begin
            median = lt_ext <<< 1;
        end else if (r_usize > r_lsize) begin
            median = ut_ext <<< 1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_hsel      = r_hsel;
        n_lsize     = r_lsize;
        n_usize     = r_usize;
        n_m         = r_m;
        n_idx       = r_idx;
        n_val       = r_val;
        n_carry     = r_carry;
        n_cand      = r_cand;
        n_left_win  = r_left_win;
        n_full      = r_full;
        n_rebal     = r_rebal;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        we_l        = 1'b0;
        we_u        = 1'b0;
        waddr       = r_idx;
        wdata       = r_val;
        raddr       = r_idx;
        cmp_a       = r_val;
        cmp_b       = q;
        cmp_max     = (r_hsel == rmth_pkg::HEAP_LOWER);
        o_s_axis_tready = 1'b0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rmth_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_val   = SW'(i_s_axis_tdata);
                    n_rebal = 1'b0;
                    n_full  = 1'b0;
                    if (i_s_axis_tuser) begin
                        n_lsize = '0;
                        n_usize = '0;
                        n_state = rmth_pkg::ST_PLACE;
                    end else if (total >= CAPACITY) begin
                        n_full  = 1'b1;
                        n_state = rmth_pkg::ST_RESULT;
                    end else begin
                        n_state = rmth_pkg::ST_PLACE;
                    end
                end
            end
            rmth_pkg::ST_PLACE: begin
                // pick the heap: upper when above the lower top
                cmp_b   = r_ltop;
                cmp_max = 1'b1;
                if (r_lsize != '0 && cmp_out) begin
                    n_hsel  = rmth_pkg::HEAP_UPPER;
                    n_idx   = IW'(r_usize);
                    n_usize = r_usize + CW'(1);
                end else begin
                    n_hsel  = rmth_pkg::HEAP_LOWER;
                    n_idx   = IW'(r_lsize);
                    n_lsize = r_lsize + CW'(1);
                end
                n_state = rmth_pkg::ST_PUSH_UP;
            end
            rmth_pkg::ST_PUSH_UP: begin
                raddr = (r_idx - IW'(1)) >> 1;
                if (r_idx == '0) begin
                    we_l    = (r_hsel == rmth_pkg::HEAP_LOWER);
                    we_u    = (r_hsel == rmth_pkg::HEAP_UPPER);
                    n_state = r_rebal ? rmth_pkg::ST_RESULT : rmth_pkg::ST_REBAL;
                end else begin
                    n_state = rmth_pkg::ST_PUSH_CMP;
                end
            end
            rmth_pkg::ST_PUSH_CMP: begin
                // parent data is in q; move it down or settle the value
                we_l = (r_hsel == rmth_pkg::HEAP_LOWER);
                we_u = (r_hsel == rmth_pkg::HEAP_UPPER);
                if (cmp_out) begin
                    wdata   = q;
                    n_idx   = (r_idx - IW'(1)) >> 1;
                    n_state = rmth_pkg::ST_PUSH_UP;
                end else begin
                    n_state = r_rebal ? rmth_pkg::ST_RESULT : rmth_pkg::ST_REBAL;
                end
            end
            rmth_pkg::ST_REBAL: begin
                if (XW'(r_lsize) > XW'(r_usize) + XW'(1)) begin
                    n_hsel  = rmth_pkg::HEAP_LOWER;
                    n_state = rmth_pkg::ST_POP_LAST;
                end else if (XW'(r_usize) > XW'(r_lsize) + XW'(1)) begin
                    n_hsel  = rmth_pkg::HEAP_UPPER;
                    n_state = rmth_pkg::ST_POP_LAST;
                end else begin
                    n_state = rmth_pkg::ST_RESULT;
                end
            end
            rmth_pkg::ST_POP_LAST: begin
                // take the top, fetch the tail entry
                n_m     = cur_size - CW'(1);
                raddr   = IW'(cur_size - CW'(1));
                n_carry = (r_hsel == rmth_pkg::HEAP_UPPER) ? r_utop : r_ltop;
                if (r_hsel == rmth_pkg::HEAP_UPPER) begin
                    n_usize = r_usize - CW'(1);
                end else begin
                    n_lsize = r_lsize - CW'(1);
                end
                n_state = rmth_pkg::ST_POP_TAIL;
            end
            rmth_pkg::ST_POP_TAIL: begin
                n_val   = q;
                n_idx   = '0;
                n_state = rmth_pkg::ST_POP_L;
            end
            rmth_pkg::ST_POP_L: begin
                raddr = IW'(child_l);
                if (child_l >= m_ext) begin
                    we_l    = (r_hsel == rmth_pkg::HEAP_LOWER);
                    we_u    = (r_hsel == rmth_pkg::HEAP_UPPER);
                    // hand the old top to the other heap
                    n_rebal = 1'b1;
                    n_val   = r_carry;
                    if (r_hsel == rmth_pkg::HEAP_LOWER) begin
                        n_hsel  = rmth_pkg::HEAP_UPPER;
                        n_idx   = IW'(r_usize);
                        n_usize = r_usize + CW'(1);
                    end else begin
                        n_hsel  = rmth_pkg::HEAP_LOWER;
                        n_idx   = IW'(r_lsize);
                        n_lsize = r_lsize + CW'(1);
                    end
                    n_state = rmth_pkg::ST_PUSH_UP;
                end else begin
                    n_state = rmth_pkg::ST_POP_R;
                end
            end
            rmth_pkg::ST_POP_R: begin
                // left child in q: compare it against the hole value
                cmp_a      = q;
                cmp_b      = r_val;
                n_left_win = cmp_out;
                n_cand     = cmp_out ? q : r_val;
                raddr      = IW'(child_r);
                n_state    = rmth_pkg::ST_POP_CMP;
            end
            rmth_pkg::ST_POP_CMP: begin
                cmp_a = q;
                cmp_b = r_cand;
                if (child_r < m_ext && cmp_out) begin
                    we_l    = (r_hsel == rmth_pkg::HEAP_LOWER);
                    we_u    = (r_hsel == rmth_pkg::HEAP_UPPER);
                    wdata   = q;
                    n_idx   = IW'(child_r);
                    n_state = rmth_pkg::ST_POP_L;
                end else if (r_left_win) begin
                    we_l    = (r_hsel == rmth_pkg::HEAP_LOWER);
                    we_u    = (r_hsel == rmth_pkg::HEAP_UPPER);
                    wdata   = r_cand;
                    n_idx   = IW'(child_l);
                    n_state = rmth_pkg::ST_POP_L;
                end else begin
                    // hole value settles here; reuse the end-of-pop path
                    n_m     = CW'(0);
                    n_state = rmth_pkg::ST_POP_L;
                end
            end
            rmth_pkg::ST_RESULT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {5'b0, NW'(total), median};
                    n_out_user  = r_full;
                    n_state     = rmth_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rmth_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmth_pkg::ST_IDLE;
            r_lsize     <= '0;
            r_usize     <= '0;
            r_out_valid <= 1'b0;
            r_rebal     <= 1'b0;
            r_full      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lsize     <= n_lsize;
            r_usize     <= n_usize;
            r_out_valid <= n_out_valid;
            r_rebal     <= n_rebal;
            r_full      <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hsel     <= n_hsel;
        r_m        <= n_m;
        r_idx      <= n_idx;
        r_val      <= n_val;
        r_carry    <= n_carry;
        r_cand     <= n_cand;
        r_left_win <= n_left_win;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        if (we_l && waddr == '0) begin
            r_ltop <= wdata;
        end
        if (we_u && waddr == '0) begin
            r_utop <= wdata;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    assign sizes_fit  = (XW'(r_lsize) <= XW'(HEAP_DEPTH)) && (XW'(r_usize) <= XW'(HEAP_DEPTH));
    assign sizes_even = (XW'(r_lsize) <= XW'(r_usize) + XW'(1))
                     && (XW'(r_usize) <= XW'(r_lsize) + XW'(1));

`include "running_median_two_heaps_assert.svh"

    `RMTH_ASSERT(a_heap_bound, sizes_fit, "heap size beyond depth")
    `RMTH_ASSERT(a_balanced, (r_state != rmth_pkg::ST_IDLE) || sizes_even, "heaps out of balance")
    `RMTH_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "ready right after accept")
    `RMTH_ASSERT(a_one_write, !(we_l && we_u), "both heaps written at once")

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int DEPTH    = 512;
    localparam int CAPACITY = 2 * DEPTH - 1;

    // One expected output item: twice the median, held count, drop flag.
    typedef struct {
        logic [rmth_pkg::MEDIAN_W-1:0] median2;
        logic [rmth_pkg::COUNT_W-1:0]  count;
        logic                          dropped;
    } t_median_result;

    // Two-heap median tracker plus the queue of results still owed by the block.
    class t_median_scoreboard;
        int lower_q[DEPTH];   // max-heap, smaller half
        int upper_q[DEPTH];   // min-heap, larger half
        int n_lower;
        int n_upper;
        t_median_result owed[$];
        int errors;

        function int rd(rmth_pkg::t_heap h, int i);
            return (h == rmth_pkg::HEAP_LOWER) ? lower_q[i] : upper_q[i];
        endfunction

        function void wr(rmth_pkg::t_heap h, int i, int v);
            if (h == rmth_pkg::HEAP_LOWER) lower_q[i] = v;
            else upper_q[i] = v;
        endfunction

        // Does a sit closer to the top than b in heap h?
        function bit above(rmth_pkg::t_heap h, int a, int b);
            return (h == rmth_pkg::HEAP_LOWER) ? (a > b) : (a < b);
        endfunction

        function void push(rmth_pkg::t_heap h, int v);
            int i;
            int p;
            int t;
            i = (h == rmth_pkg::HEAP_LOWER) ? n_lower : n_upper;
            if (i >= DEPTH) return;
            wr(h, i, v);
            if (h == rmth_pkg::HEAP_LOWER) n_lower++;
            else n_upper++;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!above(h, rd(h, i), rd(h, p))) break;
                t = rd(h, i);
                wr(h, i, rd(h, p));
                wr(h, p, t);
                i = p;
            end
        endfunction

        function int pop(rmth_pkg::t_heap h);
            int top;
            int m;
            int i;
            int l;
            int best;
            int t;
            top = rd(h, 0);
            if (h == rmth_pkg::HEAP_LOWER) begin
                n_lower--;
                m = n_lower;
            end else begin
                n_upper--;
                m = n_upper;
            end
            wr(h, 0, rd(h, m));
            i = 0;
            forever begin
                l = 2 * i + 1;
                best = i;
                if (l < m && above(h, rd(h, l), rd(h, best))) best = l;
                if (l + 1 < m && above(h, rd(h, l + 1), rd(h, best))) best = l + 1;
                if (best == i) break;
                t = rd(h, i);
                wr(h, i, rd(h, best));
                wr(h, best, t);
                i = best;
            end
            return top;
        endfunction

        // Fold one accepted sample into the heaps and queue its result.
        function void note_sample(logic [31:0] raw, logic restart);
            int s;
            longint med;
            t_median_result r;
            s = int'(raw);
            r.dropped = 1'b0;
            if (restart) begin
                n_lower = 0;
                n_upper = 0;
            end
            if (n_lower + n_upper >= CAPACITY) begin
                r.dropped = 1'b1;
            end else begin
                if (n_lower > 0 && s > lower_q[0]) push(rmth_pkg::HEAP_UPPER, s);
                else push(rmth_pkg::HEAP_LOWER, s);
                if (n_lower > n_upper + 1)
                    push(rmth_pkg::HEAP_UPPER, pop(rmth_pkg::HEAP_LOWER));
                else if (n_upper > n_lower + 1)
                    push(rmth_pkg::HEAP_LOWER, pop(rmth_pkg::HEAP_UPPER));
            end
            med = 0;
            if (n_lower > 0 && n_lower == n_upper)
                med = longint'(lower_q[0]) + longint'(upper_q[0]);
            else if (n_lower > n_upper)
                med = 2 * longint'(lower_q[0]);
            else if (n_upper > n_lower)
                med = 2 * longint'(upper_q[0]);
            r.median2 = med[rmth_pkg::MEDIAN_W-1:0];
            r.count   = rmth_pkg::COUNT_W'(n_lower + n_upper);
            owed.push_back(r);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [47:0] data, logic flag);
            localparam int MW = rmth_pkg::MEDIAN_W;
            localparam int NW = rmth_pkg::COUNT_W;
            t_median_result r;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result %h/%b", data, flag));
                return;
            end
            r = owed.pop_front();
            if (data[MW-1:0] !== r.median2)
                report($sformatf("median2 got %h want %h", data[MW-1:0], r.median2));
            if (data[MW+NW-1:MW] !== r.count)
                report($sformatf("count got %0d want %0d", data[MW+NW-1:MW], r.count));
            if (data[47:MW+NW] !== '0)
                report($sformatf("tdata pad bits set %h", data));
            if (flag !== r.dropped)
                report($sformatf("full flag got %b want %b", flag, r.dropped));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;   // [31:0] sample
    logic        s_user;   // [0] restart
    logic        m_valid;
    logic        m_ready;
    logic [47:0] m_data;   // [32:0] median_doubled, [42:33] sample_count
    logic        m_user;   // [0] full_flag

    t_median_scoreboard tracker;
    int n_results;

    running_median_two_heaps i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        tracker = new();
        n_results = 0;
    end

    // Watch both handshakes on the edge where they complete.
    always @(posedge i_clk) begin
        if (i_rst_n && s_valid && s_ready) tracker.note_sample(s_data, s_user);
        if (i_rst_n && m_valid && m_ready) begin
            tracker.check_result(m_data, m_user);
            n_results++;
        end
    end

    // Receiver: random stalls before each result, one long hold-off early on.
    initial begin
        int gap;
        int taken;
        m_ready = 1'b0;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = (taken == 40) ? 400 : $urandom_range(0, 8);
            if (($urandom_range(0, 3) == 0) && taken != 40) gap = 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
            taken++;
        end
    end

    // Offer one item after a random gap; leave tvalid high for the next call.
    task automatic send_sample(input logic [31:0] sample, input logic restart);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= sample;
        s_user  <= restart;
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.owed.size() != 0) @(posedge i_clk);
    endtask

    // Mix of wide random values, a narrow band full of repeats, and the extremes.
    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2: return 32'($signed($urandom_range(0, 20)) - 10);
            default: return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    initial begin
        s_valid = 1'b0;
        s_data  = '0;
        s_user  = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, ties with the lower top, odd and even counts.
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h0000_0001, 1'b1);   // restart, single sample held
        send_sample(32'h0000_0001, 1'b0);   // equal to lower top: goes low
        send_sample(32'h0000_0002, 1'b0);
        send_sample(32'hffff_fffe, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'haaaa_aaaa, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        wait_drained();   // sender pause until every result is back

        // Fill to capacity without restarts, then keep feeding dropped samples.
        send_sample(pick_sample(), 1'b1);
        for (int k = 1; k < CAPACITY + 8; k++)
            send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b1);   // restart with a full store

        // Short random runs with restarts.
        for (int k = 0; k < 70; k++)
            send_sample(pick_sample(), $urandom_range(0, 9) == 0);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.owed.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+design
design/rmth_pkg.sv
design/rmth_ram.sv
design/rmth_cmp.sv
design/running_median_two_heaps.sv
tb/testbench.sv
